// ===== rtl/core/rts_pkg.sv =====
// Shared types and constants for the rate to seven-segment display encoder.
package rts_pkg;

    localparam int NUM_WIDTH = 32;
    localparam int REM_WIDTH = 14;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [NUM_WIDTH-1:0] RATE_NUMERATOR_RESET = 32'd100000000;
    localparam logic [REM_WIDTH-1:0] DISPLAY_MODULUS = 14'd10000;
    localparam logic [REM_WIDTH-1:0] SCALE_THOUSANDS = 14'd1000;
    localparam logic [REM_WIDTH-1:0] SCALE_HUNDREDS = 14'd100;
    localparam logic [REM_WIDTH-1:0] SCALE_TENS = 14'd10;

    localparam logic [7:0] SEG_BLANK = 8'hFF;
    localparam logic [7:0] SEG_DP_MASK = 8'h7F;
    localparam logic [23:0] WORD_BLANK = 24'hFFFFFF;

    typedef struct packed {
        logic [NUM_WIDTH-1:0] elapsed;
        logic                 zero;
    } rts_req_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_stat_t;

    typedef struct packed {
        logic [NUM_WIDTH-1:0] quotient;
        logic                 zero;
    } rts_quot_t;

endpackage

// ===== rtl/core/rate_to_seven_segment.sv =====
// Top level of the rate to seven-segment display encoder.
// Each request on the input channel carries the elapsed time of one frame in microseconds.
// The block divides the rate numerator register by it and shows the four low decimal digits
// of the quotient as active-low segments reading "dd.dd": digits 2,1,0 on low_digits_word,
// two blank digits and digit 3 on high_digits_word. A zero elapsed time blanks every digit
// and raises zero_elapsed. Each request yields exactly one result, in order.
// The configuration channel writes the numerator; its ready is always high. Write it only
// while no request is in flight. Reset loads 100000000 and empties the block.
// After the edge that writes a request into the input queue, it passes through 32 divider
// stages, one saturation stage, one modulo stage per four quotient bits, three digit stages
// and the output register. Throughput is one request per cycle while the output does not
// stall. When the receiver holds ready low, the back pipeline freezes as a whole; the
// four-entry input queue keeps taking requests until it fills.
module rate_to_seven_segment
    import rts_pkg::*;
#(
    parameter int DIVIDER_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [NUM_WIDTH-1:0] elapsed_us,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [23:0]          low_digits_word,
    output logic [23:0]          high_digits_word,
    output logic                 zero_elapsed,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [NUM_WIDTH-1:0] cfg_data
);

    logic [NUM_WIDTH-1:0] rate_numerator_reg;
    logic                 adv;
    logic                 pop;
    rts_req_t             head;
    queue_stat_t          q_stat;
    logic                 div_valid;
    rts_quot_t            div_quot;

    assign cfg_ready = 1'b1;
    assign adv = !out_valid || out_ready;
    assign pop = adv && !q_stat.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_numerator_reg <= RATE_NUMERATOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            rate_numerator_reg <= cfg_data;
        end
    end

    rts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .elapsed_us (elapsed_us),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    rts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (pop),
        .in_req    (head),
        .numerator (rate_numerator_reg),
        .out_valid (div_valid),
        .out_quot  (div_quot)
    );

    rts_dec #(
        .DIVIDER_WIDTH (DIVIDER_WIDTH)
    ) u_dec (
        .clk              (clk),
        .rst_n            (rst_n),
        .adv              (adv),
        .in_valid         (div_valid),
        .in_quot          (div_quot),
        .out_valid        (out_valid),
        .low_digits_word  (low_digits_word),
        .high_digits_word (high_digits_word),
        .zero_elapsed     (zero_elapsed)
    );

`ifndef SYNTHESIS
    a_zero_blanks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_elapsed |-> low_digits_word == WORD_BLANK
                                      && high_digits_word == WORD_BLANK)
        else $error("zero elapsed result is not blank");

    a_digit_layout: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_elapsed |-> high_digits_word[23:8] == {SEG_BLANK, SEG_BLANK}
                                       && !low_digits_word[23])
        else $error("upper digits not blank or decimal point not lit");

    a_queue_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("input queue is both empty and full");

    a_reset_clears: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && q_stat.empty)
        else $error("pipeline not empty after reset");
`endif

endmodule

// ===== rtl/core/rts_front.sv =====
// Front end: takes requests, flags a zero elapsed time and queues them for the divider.
module rts_front
    import rts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [NUM_WIDTH-1:0] elapsed_us,
    input  logic                 pop,
    output rts_req_t             head,
    output queue_stat_t          stat
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    rts_req_t         queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;
    logic             push;
    rts_req_t         push_req;

    assign in_ready = (count_reg != (PTR_W + 1)'(QUEUE_DEPTH));
    assign push = in_valid && in_ready;
    assign stat.empty = (count_reg == '0);
    assign stat.full = !in_ready;
    assign head = queue_reg[rd_ptr_reg];

    always_comb
    begin
        push_req.elapsed = elapsed_us;
        push_req.zero = (elapsed_us == '0);
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/rts_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, the whole pipe advances together.
module rts_div
    import rts_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  rts_req_t             in_req,
    input  logic [NUM_WIDTH-1:0] numerator,
    output logic                 out_valid,
    output rts_quot_t            out_quot
);

    localparam int DIV_STAGES = NUM_WIDTH;

    typedef struct packed {
        logic [NUM_WIDTH-1:0] num;
        logic [NUM_WIDTH-1:0] den;
        logic [NUM_WIDTH-1:0] rem;
        logic [NUM_WIDTH-1:0] quo;
        logic                 zero;
    } div_stage_t;

    div_stage_t            stage_reg  [DIV_STAGES];
    div_stage_t            stage_next [DIV_STAGES];
    div_stage_t            src_stage  [DIV_STAGES];
    logic [DIV_STAGES-1:0] valid_reg;

    always_comb
    begin
        src_stage[0].num = numerator;
        src_stage[0].den = in_req.elapsed;
        src_stage[0].rem = '0;
        src_stage[0].quo = '0;
        src_stage[0].zero = in_req.zero;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            src_stage[s] = stage_reg[s-1];
        end
    end

    // Shift in the next numerator bit, then subtract the divisor when it fits.
    always_comb
    begin
        logic [NUM_WIDTH:0] trial;
        logic [NUM_WIDTH:0] diff;
        logic               fits;
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            trial = {src_stage[s].rem, src_stage[s].num[NUM_WIDTH-1-s]};
            diff = trial - {1'b0, src_stage[s].den};
            fits = !diff[NUM_WIDTH];
            stage_next[s] = src_stage[s];
            stage_next[s].rem = fits ? diff[NUM_WIDTH-1:0] : trial[NUM_WIDTH-1:0];
            stage_next[s].quo[NUM_WIDTH-1-s] = fits;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            stage_reg <= stage_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_quot.quotient = stage_reg[DIV_STAGES-1].quo;
    assign out_quot.zero = stage_reg[DIV_STAGES-1].zero;

endmodule

// ===== rtl/core/rts_dec.sv =====
// Back end: saturates the quotient, takes its four low decimal digits and drives the segments.
module rts_dec
    import rts_pkg::*;
#(
    parameter int DIVIDER_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  logic        in_valid,
    input  rts_quot_t   in_quot,
    output logic        out_valid,
    output logic [23:0] low_digits_word,
    output logic [23:0] high_digits_word,
    output logic        zero_elapsed
);

    localparam int WIDE_W = 2 * NUM_WIDTH;
    localparam int MOD_STAGES = (DIVIDER_WIDTH + 3) / 4;
    localparam int MOD_W = MOD_STAGES * 4;
    localparam int DIG_STAGES = 3;

    typedef struct packed {
        logic [MOD_W-1:0]     q;
        logic [REM_WIDTH-1:0] r;
        logic                 zero;
    } mod_stage_t;

    typedef struct packed {
        logic [3:0]           d3;
        logic [3:0]           d2;
        logic [3:0]           d1;
        logic [3:0]           d0;
        logic [REM_WIDTH-1:0] rest;
        logic                 zero;
    } dig_stage_t;

    typedef struct packed {
        logic [3:0]           digit;
        logic [REM_WIDTH-1:0] rest;
    } split_t;

    // Four steps of r = (2r + bit) mod 10000; 2r + bit never reaches twice the modulus.
    function automatic logic [REM_WIDTH-1:0] mod_step(input logic [REM_WIDTH-1:0] r_in,
                                                      input logic [3:0] bits);
        logic [REM_WIDTH:0]   t;
        logic [REM_WIDTH-1:0] r;
        r = r_in;
        for (int i = 0; i < 4; i++)
        begin
            t = {r, bits[3-i]};
            if (t >= {1'b0, DISPLAY_MODULUS})
            begin
                t = t - {1'b0, DISPLAY_MODULUS};
            end
            r = t[REM_WIDTH-1:0];
        end
        return r;
    endfunction

    // Leading digit of a value below ten times the scale, by parallel threshold compares.
    function automatic split_t digit_split(input logic [REM_WIDTH-1:0] value,
                                           input logic [REM_WIDTH-1:0] scale);
        split_t     res;
        logic [3:0] cnt;
        cnt = '0;
        for (int k = 1; k <= 9; k++)
        begin
            if (value >= REM_WIDTH'(k) * scale)
            begin
                cnt = cnt + 4'd1;
            end
        end
        res.digit = cnt;
        res.rest = value - REM_WIDTH'(cnt) * scale;
        return res;
    endfunction

    function automatic logic [7:0] seg_encode(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

    logic [DIVIDER_WIDTH-1:0] sat_q_reg;
    logic [DIVIDER_WIDTH-1:0] sat_q_next;
    logic                     sat_zero_reg;
    logic                     sat_valid_reg;
    logic [WIDE_W-1:0]        q_wide;
    logic                     q_over;

    mod_stage_t               mod_reg  [MOD_STAGES];
    mod_stage_t               mod_next [MOD_STAGES];
    mod_stage_t               mod_src  [MOD_STAGES];
    logic [MOD_STAGES-1:0]    mod_valid_reg;

    dig_stage_t               dig_reg  [DIG_STAGES];
    dig_stage_t               dig_next [DIG_STAGES];
    logic [DIG_STAGES-1:0]    dig_valid_reg;

    logic [23:0]              low_reg;
    logic [23:0]              low_next;
    logic [23:0]              high_reg;
    logic [23:0]              high_next;
    logic                     zero_reg;
    logic                     out_valid_reg;

    // A quotient wider than the configured width is clamped to its largest value.
    always_comb
    begin
        q_wide = WIDE_W'(in_quot.quotient);
        q_over = ((q_wide >> DIVIDER_WIDTH) != '0);
        sat_q_next = q_over ? '1 : q_wide[DIVIDER_WIDTH-1:0];
    end

    always_comb
    begin
        mod_src[0].q = MOD_W'(sat_q_reg);
        mod_src[0].r = '0;
        mod_src[0].zero = sat_zero_reg;
        for (int k = 1; k < MOD_STAGES; k++)
        begin
            mod_src[k] = mod_reg[k-1];
        end
        for (int k = 0; k < MOD_STAGES; k++)
        begin
            mod_next[k] = mod_src[k];
            mod_next[k].r = mod_step(mod_src[k].r, mod_src[k].q[MOD_W-1-4*k -: 4]);
        end
    end

    always_comb
    begin
        split_t sp3;
        split_t sp2;
        split_t sp1;
        sp3 = digit_split(mod_reg[MOD_STAGES-1].r, SCALE_THOUSANDS);
        dig_next[0].d3 = sp3.digit;
        dig_next[0].d2 = '0;
        dig_next[0].d1 = '0;
        dig_next[0].d0 = '0;
        dig_next[0].rest = sp3.rest;
        dig_next[0].zero = mod_reg[MOD_STAGES-1].zero;

        sp2 = digit_split(dig_reg[0].rest, SCALE_HUNDREDS);
        dig_next[1] = dig_reg[0];
        dig_next[1].d2 = sp2.digit;
        dig_next[1].rest = sp2.rest;

        sp1 = digit_split(dig_reg[1].rest, SCALE_TENS);
        dig_next[2] = dig_reg[1];
        dig_next[2].d1 = sp1.digit;
        dig_next[2].d0 = sp1.rest[3:0];
        dig_next[2].rest = '0;
    end

    always_comb
    begin
        if (dig_reg[DIG_STAGES-1].zero)
        begin
            low_next = WORD_BLANK;
            high_next = WORD_BLANK;
        end
        else
        begin
            low_next = {seg_encode(dig_reg[DIG_STAGES-1].d2) & SEG_DP_MASK,
                        seg_encode(dig_reg[DIG_STAGES-1].d1),
                        seg_encode(dig_reg[DIG_STAGES-1].d0)};
            high_next = {SEG_BLANK, SEG_BLANK, seg_encode(dig_reg[DIG_STAGES-1].d3)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_q_reg    <= sat_q_next;
            sat_zero_reg <= in_quot.zero;
            mod_reg      <= mod_next;
            dig_reg      <= dig_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            zero_reg     <= dig_reg[DIG_STAGES-1].zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_valid_reg <= 1'b0;
            mod_valid_reg <= '0;
            dig_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sat_valid_reg <= in_valid;
            mod_valid_reg <= {mod_valid_reg[MOD_STAGES-2:0], sat_valid_reg};
            dig_valid_reg <= {dig_valid_reg[DIG_STAGES-2:0], mod_valid_reg[MOD_STAGES-1]};
            out_valid_reg <= dig_valid_reg[DIG_STAGES-1];
        end
    end

    assign out_valid = out_valid_reg;
    assign low_digits_word = low_reg;
    assign high_digits_word = high_reg;
    assign zero_elapsed = zero_reg;

endmodule
